### sv/assert_macros.svh
// assertion macros shared by the gyro bias calibration rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define GBC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/gbc_pkg.sv
// shared types and constants for the gyro bias calibration block
package gbc_pkg;

	localparam int AXES   = 3;
	localparam int DATA_W = 16;
	localparam int SUM_W  = 32;
	localparam int OFS_W  = 25;
	localparam int NUM_W  = 40;
	localparam int QUO_W  = 24;
	localparam int CNT_W  = 16;
	localparam int STEP_W = $clog2(QUO_W);

	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 16'd16000;
	localparam logic [CNT_W-1:0] MOTION_LIMIT_RST = 16'd200;
	localparam logic [CNT_W-1:0] RATE_DEN         = 16'd1312;

	// rate divide by 1312 = 32 * 41: shift right by 5, then multiply by ceil(2^28 / 41)
	localparam int PRE_SH   = 5;
	localparam int PRE_W    = 22;
	localparam int RECIP_W  = 23;
	localparam int RECIP_SH = 28;
	localparam int PROD_W   = PRE_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RATE_RECIP = 23'd6547207;

	localparam logic signed [DATA_W-1:0] RATE_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] RATE_MIN = 16'sh8000;

	localparam logic KIND_SAMPLE   = 1'b0;
	localparam logic KIND_START    = 1'b1;
	localparam logic RESULT_MOTION = 1'b0;
	localparam logic RESULT_CAL    = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTION_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CAL   = 2'd1,
		MODE_READY = 2'd2
	} mode_t;

	typedef enum logic {
		OP_RATE   = 1'b0,
		OP_OFFSET = 1'b1
	} lane_op_t;

	typedef struct packed {
		logic                     kind;
		logic signed [DATA_W-1:0] accel_x;
		logic signed [DATA_W-1:0] accel_y;
		logic signed [DATA_W-1:0] accel_z;
		logic signed [DATA_W-1:0] gyro_x;
		logic signed [DATA_W-1:0] gyro_y;
		logic signed [DATA_W-1:0] gyro_z;
	} sample_t;

	typedef struct packed {
		logic                     result_kind;
		logic signed [DATA_W-1:0] out_accel_x;
		logic signed [DATA_W-1:0] out_accel_y;
		logic signed [DATA_W-1:0] out_accel_z;
		logic signed [DATA_W-1:0] rate_x;
		logic signed [DATA_W-1:0] rate_y;
		logic signed [DATA_W-1:0] rate_z;
		logic                     calibration_ok;
	} result_t;

	// command from the control to one divider lane
	typedef struct packed {
		logic                     start;
		lane_op_t                 op;
		logic signed [DATA_W-1:0] gyro;
		logic signed [OFS_W-1:0]  ofs;
		logic signed [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]         cnt;
	} lane_cmd_t;

	// status back from one divider lane
	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic signed [QUO_W:0]  quot;
	} lane_stat_t;

	// request to the merge stage to load the output word
	typedef struct packed {
		logic                     load;
		logic                     cal;
		logic                     ok;
		logic signed [DATA_W-1:0] ax;
		logic signed [DATA_W-1:0] ay;
		logic signed [DATA_W-1:0] az;
	} emit_t;

endpackage

### sv/gbc_if.sv
// channel interfaces: sample input, result output, configuration writes
interface gbc_sample_if import gbc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface gbc_result_if import gbc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface gbc_cfg_if import gbc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CNT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/gbc_lane.sv
// one axis lane: signed round-to-nearest divide, serial for offsets, reciprocal multiply for rates
module gbc_lane import gbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_cmd_t  cmd,
	output lane_stat_t stat
);

	logic signed [NUM_W-1:0] g_q8;
	logic signed [NUM_W-1:0] ofs_ext;
	logic signed [NUM_W-1:0] diff;
	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]        mag;
	logic [NUM_W-1:0]        dividend;
	logic [CNT_W:0]          trial;
	logic                    ge;
	logic [PROD_W-1:0]       prod;

	logic                    busy_q;
	logic                    load_q;
	logic                    done_q;
	logic                    neg_q;
	lane_op_t                op_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [NUM_W-1:0] num_q;
	logic [CNT_W-1:0]        den_q;
	logic [CNT_W-1:0]        rem_q;
	logic [QUO_W-1:0]        dq_q;

	// numerator: offset is sum*256, rate is (gyro*256 - offset)*5
	always_comb begin
		g_q8    = $signed({{(NUM_W-DATA_W-8){cmd.gyro[DATA_W-1]}}, cmd.gyro, 8'd0});
		ofs_ext = $signed({{(NUM_W-OFS_W){cmd.ofs[OFS_W-1]}}, cmd.ofs});
		diff    = g_q8 - ofs_ext;
		if (cmd.op == OP_OFFSET) begin
			num = $signed({cmd.sum, 8'd0});
		end else begin
			num = (diff <<< 2) + diff;
		end
	end

	// magnitude plus half the divisor gives ties away from zero
	assign mag      = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dividend = mag + NUM_W'(den_q >> 1);

	assign trial = {rem_q, dq_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// rate: (dividend >> 5) / 41, exact for the 22-bit range
	assign prod = PROD_W'(dq_q[PRE_W-1:0]) * PROD_W'(RATE_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			load_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				load_q <= 1'b1;
			end else if (load_q) begin
				load_q <= 1'b0;
			end else if (busy_q && (op_q == OP_RATE || step_q == STEP_W'(QUO_W-1))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= num;
			op_q  <= cmd.op;
			den_q <= (cmd.op == OP_OFFSET) ? cmd.cnt : RATE_DEN;
		end else if (load_q) begin
			neg_q  <= num_q[NUM_W-1];
			rem_q  <= dividend[NUM_W-1 -: CNT_W];
			dq_q   <= (op_q == OP_RATE) ? dividend[QUO_W+PRE_SH-1:PRE_SH] :
				dividend[QUO_W-1:0];
			step_q <= '0;
		end else if (busy_q) begin
			if (op_q == OP_RATE) begin
				dq_q <= QUO_W'(prod[PROD_W-1:RECIP_SH]);
			end else begin
				rem_q  <= ge ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
				dq_q   <= {dq_q[QUO_W-2:0], ge};
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

endmodule

### sv/gbc_merge.sv
// merge stage: saturates lane quotients, builds the result word, output register
module gbc_merge import gbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  emit_t           emit,
	input  lane_stat_t      lane_stat [AXES],
	output logic            free,
	gbc_result_if.source    result
);

	logic                     vld_q;
	result_t                  item_q;
	result_t                  nxt;
	logic signed [DATA_W-1:0] rate [AXES];

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [QUO_W:0] v);
		logic fits;
		fits = (&v[QUO_W:DATA_W-1]) | ~(|v[QUO_W:DATA_W-1]);
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[QUO_W]) begin
			return RATE_MIN;
		end else begin
			return RATE_MAX;
		end
	endfunction

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			rate[i] = sat16(lane_stat[i].quot);
		end
		nxt = '0;
		if (emit.cal) begin
			nxt.result_kind    = RESULT_CAL;
			nxt.calibration_ok = emit.ok;
		end else begin
			nxt.result_kind = RESULT_MOTION;
			nxt.out_accel_x = emit.ax;
			nxt.out_accel_y = emit.ay;
			nxt.out_accel_z = emit.az;
			nxt.rate_x      = rate[0];
			nxt.rate_y      = rate[1];
			nxt.rate_z      = rate[2];
		end
	end

	assign free = !vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (emit.load) begin
			vld_q <= 1'b1;
		end else if (result.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			item_q <= nxt;
		end
	end

	assign result.valid = vld_q;
	assign result.item  = item_q;

endmodule

### sv/gyro_bias_calibrate_correct.sv
// top level: gyro bias calibration and rate correction
//
// channels: sample (sink) takes one word per IMU sample or start command,
// result (source) gives at most one word per sample word, cfg (sink) writes
// sample_count (index 0) and motion_limit (index 1); cfg is always ready.
// a start command or an idle-mode sample gives no result and leaves the
// sequencer idle. a motion abort during calibration gives its failure word
// through ST_EMIT and the output register, and the next word is taken once
// the sequencer is back in ST_IDLE. a ready-mode sample runs three lanes
// side by side, each a shift and a reciprocal multiply; its word passes the
// lane load and multiply registers, ST_DIV, ST_EMIT and the output register,
// and no next sample word is taken before the sequencer is back in ST_IDLE.
// the last calibration sample runs the lanes as serial dividers, one offset
// bit per cycle for 24 bits, and the next word waits for the 24-step divide.
// reset clears mode to idle, sums, counter, previous gyro and offsets, and
// loads sample_count 16000 and motion_limit 200.
// when the receiver stalls, the result waits in the output register and
// sample words are still taken; once another word is ready to load, sample
// ready is held low until the output register frees up.
`include "assert_macros.svh"

module gyro_bias_calibrate_correct import gbc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	gbc_cfg_if.sink       cfg,
	gbc_sample_if.sink    sample,
	gbc_result_if.source  result
);

	// control sequencer, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} ctl_state_t;

	// configuration registers
	logic [CNT_W-1:0]         sample_count_q;
	logic [CNT_W-1:0]         motion_limit_q;

	// calibration state
	mode_t                    mode_q;
	logic signed [DATA_W-1:0] prev_q [AXES];
	logic signed [SUM_W-1:0]  sum_q  [AXES];
	logic [CNT_W-1:0]         cnt_q;
	logic signed [OFS_W-1:0]  ofs_q  [AXES];

	// sequencer and pending-word state
	ctl_state_t               st_q;
	lane_op_t                 op_q;
	logic                     cal_q;
	logic                     ok_q;
	logic signed [DATA_W-1:0] accel_q [AXES];

	logic                     accept;
	logic                     out_free;
	logic signed [DATA_W-1:0] g     [AXES];
	logic signed [DATA_W-1:0] accel [AXES];
	logic signed [DATA_W:0]   diff  [AXES];
	logic [DATA_W:0]          adiff [AXES];
	logic [AXES-1:0]          moved_ax;
	logic                     moved;
	logic signed [SUM_W-1:0]  sum_nxt [AXES];
	logic [CNT_W-1:0]         cnt_nxt;
	logic                     complete;
	logic                     lane_go;
	lane_op_t                 lane_op;
	lane_cmd_t                lane_cmd  [AXES];
	lane_stat_t               lane_stat [AXES];
	emit_t                    emit;

	// config port, never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			motion_limit_q <= MOTION_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SAMPLE_COUNT: sample_count_q <= cfg.data;
				CFG_MOTION_LIMIT: motion_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// sample words are taken only when the sequencer is free
	assign sample.ready = (st_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;

	assign g[0]     = sample.item.gyro_x;
	assign g[1]     = sample.item.gyro_y;
	assign g[2]     = sample.item.gyro_z;
	assign accel[0] = sample.item.accel_x;
	assign accel[1] = sample.item.accel_y;
	assign accel[2] = sample.item.accel_z;

	// per-axis motion check and running sums, all axes in parallel
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			diff[i]     = $signed({g[i][DATA_W-1], g[i]}) - $signed({prev_q[i][DATA_W-1], prev_q[i]});
			adiff[i]    = diff[i][DATA_W] ? (DATA_W+1)'(-diff[i]) : (DATA_W+1)'(diff[i]);
			moved_ax[i] = adiff[i] > {1'b0, motion_limit_q};
			sum_nxt[i]  = sum_q[i] + SUM_W'(g[i]);
		end
	end

	assign moved    = |moved_ax;
	assign cnt_nxt  = cnt_q + 1'b1;
	assign complete = (cnt_nxt >= sample_count_q) && (cnt_nxt != '0);

	// lanes start on a ready-mode sample or on the sample that ends calibration
	assign lane_op = (mode_q == MODE_READY) ? OP_RATE : OP_OFFSET;
	assign lane_go = accept && (sample.item.kind == KIND_SAMPLE) &&
		((mode_q == MODE_READY) || (mode_q == MODE_CAL && !moved && complete));

	generate
		for (genvar i = 0; i < AXES; i++) begin : g_lane
			assign lane_cmd[i].start = lane_go;
			assign lane_cmd[i].op    = lane_op;
			assign lane_cmd[i].gyro  = g[i];
			assign lane_cmd[i].ofs   = ofs_q[i];
			assign lane_cmd[i].sum   = sum_nxt[i];
			assign lane_cmd[i].cnt   = cnt_nxt;

			gbc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (lane_cmd[i]),
				.stat   (lane_stat[i])
			);
		end
	endgenerate

	// calibration state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			for (int i = 0; i < AXES; i++) begin
				prev_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else if (accept) begin
			if (sample.item.kind == KIND_START) begin
				// restart from any mode
				mode_q <= MODE_CAL;
				cnt_q  <= '0;
				for (int i = 0; i < AXES; i++) begin
					sum_q[i] <= '0;
				end
			end else begin
				for (int i = 0; i < AXES; i++) begin
					prev_q[i] <= g[i];
				end
				case (mode_q)
					MODE_CAL: begin
						cnt_q <= cnt_nxt;
						for (int i = 0; i < AXES; i++) begin
							sum_q[i] <= sum_nxt[i];
						end
						if (moved) begin
							mode_q <= MODE_IDLE;
						end else if (complete) begin
							mode_q <= MODE_READY;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// offsets are written when the lanes finish an offset divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				ofs_q[i] <= '0;
			end
		end else if (st_q == ST_DIV && lane_stat[0].done && op_q == OP_OFFSET) begin
			for (int i = 0; i < AXES; i++) begin
				ofs_q[i] <= OFS_W'(lane_stat[i].quot);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (lane_go) begin
						st_q <= ST_DIV;
					end else if (accept && sample.item.kind == KIND_SAMPLE &&
							mode_q == MODE_CAL && moved) begin
						st_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (lane_stat[0].done) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// pending word fields, captured at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= lane_op;
			cal_q <= (mode_q != MODE_READY);
			ok_q  <= !moved;
			for (int i = 0; i < AXES; i++) begin
				accel_q[i] <= accel[i];
			end
		end
	end

	assign emit.load = (st_q == ST_EMIT) && out_free;
	assign emit.cal  = cal_q;
	assign emit.ok   = ok_q;
	assign emit.ax   = accel_q[0];
	assign emit.ay   = accel_q[1];
	assign emit.az   = accel_q[2];

	gbc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.lane_stat (lane_stat),
		.free      (out_free),
		.result    (result)
	);

	// lanes are started together and must finish together
	`GBC_ASSERT(a_lanes_lockstep, clk, arst_n, (lane_stat[0].done == lane_stat[1].done) && (lane_stat[1].done == lane_stat[2].done), "divider lanes out of step")
	// no divide may be in flight while new samples are taken
	`GBC_ASSERT(a_idle_lanes_quiet, clk, arst_n, (st_q == ST_IDLE) |-> !lane_stat[0].busy, "lane busy while sequencer idle")
	// a divide finishes only while the sequencer waits for it
	`GBC_NEVER(a_done_outside_div, clk, arst_n, lane_stat[0].done && (st_q != ST_DIV), "lane finished outside divide wait")
	// an emitted word shows up on the result channel next cycle
	`GBC_ASSERT(a_emit_shows, clk, arst_n, (st_q == ST_EMIT && out_free) |=> result.valid, "emitted word not presented")

endmodule

### sim/gyro_bias_calibrate_correct_checker.sv
// checker: predicts the calibration and rate words of the block and compares them
`timescale 1ns / 1ps

module gyro_bias_calibrate_correct_checker import gbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	gbc_cfg_if    cfg,
	gbc_sample_if sample,
	gbc_result_if result,
	output int    errors,
	output int    pending
);

	localparam longint Q8       = 256;
	localparam longint RATE_NUM = 5;
	localparam longint RATE_DIV = 1312;

	result_t expected_words[$];
	mode_t   mode;
	int      prev_gyro [AXES];
	longint  gyro_sum  [AXES];
	longint  gyro_ofs  [AXES];
	int      still_cnt;
	int      cnt_target;
	int      move_limit;

	// round to nearest, ties away from zero
	function automatic longint div_nearest(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	// corrected gyro in 1/16 dps, saturated
	function automatic logic signed [DATA_W-1:0] to_rate(int raw, longint ofs);
		longint q;
		q = div_nearest((longint'(raw) * Q8 - ofs) * RATE_NUM, RATE_DIV);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[DATA_W-1:0];
	endfunction

	task automatic predict(input sample_t w);
		result_t r;
		int      g [AXES];
		int      diff;
		bit      moved;
		r     = '0;
		moved = 1'b0;
		if (w.kind == KIND_START) begin
			still_cnt = 0;
			foreach (gyro_sum[a])
				gyro_sum[a] = 0;
			mode = MODE_CAL;
			return;
		end
		g[0] = int'(w.gyro_x);
		g[1] = int'(w.gyro_y);
		g[2] = int'(w.gyro_z);
		case (mode)
			MODE_READY: begin
				r.result_kind = RESULT_MOTION;
				r.out_accel_x = w.accel_x;
				r.out_accel_y = w.accel_y;
				r.out_accel_z = w.accel_z;
				r.rate_x      = to_rate(g[0], gyro_ofs[0]);
				r.rate_y      = to_rate(g[1], gyro_ofs[1]);
				r.rate_z      = to_rate(g[2], gyro_ofs[2]);
				expected_words.push_back(r);
			end
			MODE_CAL: begin
				foreach (g[a]) begin
					diff = g[a] - prev_gyro[a];
					if (diff < 0)
						diff = -diff;
					if (diff > move_limit)
						moved = 1'b1;
					gyro_sum[a] += longint'(g[a]);
				end
				still_cnt = (still_cnt + 1) & 32'h0000_ffff;
				if (moved) begin
					mode             = MODE_IDLE;
					r.result_kind    = RESULT_CAL;
					r.calibration_ok = 1'b0;
					expected_words.push_back(r);
				end else if (still_cnt >= cnt_target && still_cnt != 0) begin
					foreach (gyro_ofs[a])
						gyro_ofs[a] = div_nearest(gyro_sum[a] * Q8, longint'(still_cnt));
					mode             = MODE_READY;
					r.result_kind    = RESULT_CAL;
					r.calibration_ok = 1'b1;
					expected_words.push_back(r);
				end
			end
			default: ;
		endcase
		foreach (g[a])
			prev_gyro[a] = g[a];
	endtask

	task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
			input logic signed [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (expected_words.size() == 0) begin
			$error("result word with no word expected");
			errors++;
			return;
		end
		want = expected_words.pop_front();
		check_field("result_kind", want.result_kind, got.result_kind);
		check_field("out_accel_x", want.out_accel_x, got.out_accel_x);
		check_field("out_accel_y", want.out_accel_y, got.out_accel_y);
		check_field("out_accel_z", want.out_accel_z, got.out_accel_z);
		check_field("rate_x", want.rate_x, got.rate_x);
		check_field("rate_y", want.rate_y, got.rate_y);
		check_field("rate_z", want.rate_z, got.rate_z);
		check_field("calibration_ok", want.calibration_ok, got.calibration_ok);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			mode       = MODE_IDLE;
			still_cnt  = 0;
			cnt_target = int'(SAMPLE_COUNT_RST);
			move_limit = int'(MOTION_LIMIT_RST);
			foreach (prev_gyro[a]) begin
				prev_gyro[a] = 0;
				gyro_sum[a]  = 0;
				gyro_ofs[a]  = 0;
			end
			errors  = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready)
				check_word(result.item);
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_SAMPLE_COUNT)
					cnt_target = int'(cfg.data);
				else if (cfg.index == CFG_MOTION_LIMIT)
					move_limit = int'(cfg.data);
			end
			if (sample.valid && sample.ready)
				predict(sample.item);
			pending = expected_words.size();
		end
	end

endmodule

### sim/gyro_bias_calibrate_correct_tb.sv
// testbench top: stimulus, receiver stalls and verdict for the gyro bias calibration block
`timescale 1ns / 1ps

module gyro_bias_calibrate_correct_tb;
	import gbc_pkg::*;

	localparam int RAND_ITEMS   = 380;
	localparam int DRAIN_CYCLES = 40;       // margin after the last word
	localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk;
	logic arst_n;

	gbc_cfg_if    cfg_ch ();
	gbc_sample_if sample_ch ();
	gbc_result_if result_ch ();

	int errors;
	int pending;
	int cycles;

	bit calm;               // no gaps on either side while set
	bit hold_req;           // asks the receiver for one long hold-off
	int sent_gyro [AXES];   // gyro of the last sensor word sent
	int rand_sent;

	gyro_bias_calibrate_correct u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	// watches all three channels, predicts and compares
	gyro_bias_calibrate_correct_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.sample  (sample_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[gyro_bias_calibrate_correct] ERROR");
			$finish;
		end
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// sensor word with random accel and the given gyro
	function automatic sample_t sensor_word(int gx, int gy, int gz);
		sample_t w;
		w.kind    = KIND_SAMPLE;
		w.accel_x = DATA_W'(rand16());
		w.accel_y = DATA_W'(rand16());
		w.accel_z = DATA_W'(rand16());
		w.gyro_x  = DATA_W'(gx);
		w.gyro_y  = DATA_W'(gy);
		w.gyro_z  = DATA_W'(gz);
		return w;
	endfunction

	// start command, sensor fields are junk the block must ignore
	function automatic sample_t start_word();
		sample_t w;
		w      = sensor_word(rand16(), rand16(), rand16());
		w.kind = KIND_START;
		return w;
	endfunction

	function automatic sample_t random_word();
		return sensor_word(rand16(), rand16(), rand16());
	endfunction

	// small step from the last gyro, never beyond the motion limit
	function automatic sample_t still_word(int lim);
		int span;
		int g [AXES];
		span = (lim < 400) ? lim : 400;
		foreach (g[a]) begin
			g[a] = sent_gyro[a] + int'($urandom_range(0, 2 * span)) - span;
			if (g[a] > 32767)
				g[a] = 32767;
			else if (g[a] < -32768)
				g[a] = -32768;
		end
		return sensor_word(g[0], g[1], g[2]);
	endfunction

	// offer one word after a random gap, hold it until taken
	task automatic send_word(input sample_t w);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.item  <= w;
		do @(posedge clk); while (!sample_ch.ready);
		if (w.kind == KIND_SAMPLE) begin
			sent_gyro[0] = int'(w.gyro_x);
			sent_gyro[1] = int'(w.gyro_y);
			sent_gyro[2] = int'(w.gyro_z);
		end
	endtask

	// stop offering, wait for every expected word, then let the divider drain
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// registers change only with the block quiet
	task automatic configure(input int cnt, input int lim);
		settle();
		write_reg(CFG_SAMPLE_COUNT, cnt);
		write_reg(CFG_MOTION_LIMIT, lim);
	endtask

	// one calibration attempt with noise, then a run of data words
	task automatic run_phase(input int cnt, input int lim, input int n_after, input bit squeeze);
		int roll;
		configure(cnt, lim);
		send_word(start_word());
		repeat (cnt) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_word(random_word());     // likely motion abort
			else if (roll < 6)
				send_word(start_word());      // restart mid-run
			else
				send_word(still_word(lim));
		end
		// long receiver hold-off while words keep coming
		if (squeeze)
			hold_req = 1'b1;
		repeat (n_after) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				send_word(start_word());
			else
				send_word(random_word());
		end
		rand_sent += cnt + n_after + 1;
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (calm) begin
				result_ch.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					result_ch.ready <= 1'b1;
				end else begin
					result_ch.ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		sample_t w;
		int      cnt;
		int      lim;
		sample_ch.valid = 1'b0;
		sample_ch.item  = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = CFG_SAMPLE_COUNT;
		cfg_ch.data     = '0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		sent_gyro       = '{0, 0, 0};
		rand_sent       = 0;
		cycles          = 0;
		arst_n          = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: still run under the default motion limit, then one step past it
		calm = 1'b1;
		send_word(start_word());
		repeat (20) send_word(still_word(MOTION_LIMIT_RST));
		w        = still_word(0);
		w.gyro_x = (sent_gyro[0] < 0) ? DATA_W'(sent_gyro[0] + 201) :
			DATA_W'(sent_gyro[0] - 201);
		send_word(w);
		calm = 1'b0;

		// short calibration, then a data word with accel and gyro extremes
		configure(4, MOTION_LIMIT_RST);
		send_word(start_word());
		repeat (4) send_word(still_word(MOTION_LIMIT_RST));
		w         = sensor_word(32767, -32768, 0);
		w.accel_x = 16'sh7fff;
		w.accel_y = 16'sh8000;
		w.accel_z = 16'sh0000;
		send_word(w);
		send_word(random_word());

		// zero motion limit: any change aborts, then idle words give nothing
		configure(1, 0);
		send_word(start_word());
		send_word(sensor_word(-32768, 32767, 1));
		send_word(sensor_word(-32768, 32767, 1));
		// one-sample calibration at the extremes, then saturating rates
		send_word(start_word());
		send_word(sensor_word(-32768, 32767, 1));
		send_word(sensor_word(32767, -32768, -32768));
		send_word(sensor_word(-32768, 32767, 1));

		// widest motion limit: a full-scale jump still passes
		configure(2, 65535);
		send_word(start_word());
		send_word(sensor_word(32767, -32768, 0));
		send_word(sensor_word(-32768, 32767, 1));
		send_word(random_word());

		// restart of a running calibration
		configure(3, 100);
		send_word(start_word());
		send_word(still_word(100));
		send_word(start_word());
		repeat (3) send_word(still_word(100));
		send_word(random_word());

		// sample count lowered mid-run: done on the next sample, divisor 3
		configure(6, 100);
		send_word(start_word());
		repeat (2) send_word(still_word(100));
		configure(1, 100);
		send_word(still_word(100));
		send_word(random_word());

		// full-scale gyro with the widest limit: large sums and offsets
		configure(64, 65535);
		calm = 1'b1;
		send_word(start_word());
		repeat (64) send_word(sensor_word(-32768, 32767, -32768));
		calm = 1'b0;
		repeat (3) send_word(random_word());

		// random part, first phase fills the block behind a long hold-off
		run_phase(4, 300, 30, 1'b1);
		while (rand_sent < RAND_ITEMS) begin
			case ($urandom_range(0, 3))
				0: cnt = 1;
				1: cnt = 2;
				default: cnt = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 4))
				0: lim = 0;
				1: lim = $urandom_range(1, 50);
				2: lim = MOTION_LIMIT_RST;
				3: lim = 65535;
				default: lim = $urandom_range(0, 65535);
			endcase
			calm = ($urandom_range(0, 4) == 0);
			run_phase(cnt, lim, $urandom_range(5, 30), $urandom_range(0, 9) == 0);
		end
		calm = 1'b0;

		settle();
		if (errors == 0)
			$display("[gyro_bias_calibrate_correct] OK");
		else
			$display("[gyro_bias_calibrate_correct] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/gbc_pkg.sv
sv/gbc_if.sv
sv/gbc_lane.sv
sv/gbc_merge.sv
sv/gyro_bias_calibrate_correct.sv
sim/gyro_bias_calibrate_correct_checker.sv
sim/gyro_bias_calibrate_correct_tb.sv
